// File: design/tvs_pkg.sv
package tvs_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CountW = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    OP_PUSH_INT   = 3'd0,
    OP_PUSH_FLOAT = 3'd1,
    OP_DUP        = 3'd2,
    OP_POP_INT    = 3'd3,
    OP_POP_FLOAT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_INT   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TOP,
    ST_CONV
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  top_kind;
    logic [8:0]  count;
    logic        underflow;
    logic        overflow;
  } out_item_t;

  function automatic logic [31:0] f2i(input logic [31:0] b);
    logic [7:0]  e;
    logic [31:0] mag;
    logic [55:0] sh;
    begin
      e = b[30:23];
      mag = '0;
      sh = '0;
      if (e == 8'hFF && b[22:0] != '0) begin
        f2i = '0;
      end else if (e >= 8'd158) begin
        f2i = b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (e < 8'd127) begin
        f2i = '0;
      end else begin
        sh = {32'd0, 1'b1, b[22:0]} << (e - 8'd127);
        mag = sh[54:23];
        f2i = b[31] ? (~mag + 32'd1) : mag;
      end
    end
  endfunction

  function automatic logic [31:0] i2f(input logic [31:0] b);
    logic        s;
    logic [31:0] m;
    logic [31:0] n;
    logic [4:0]  lz;
    logic [7:0]  ex;
    logic [24:0] r;
    logic        g;
    logic        st;
    begin
      s = b[31];
      m = s ? (~b + 32'd1) : b;
      lz = '0;
      for (int i = 0; i < 32; i++) begin
        if (m[i]) lz = 5'(31 - i);
      end
      n = m << lz;
      g = n[7];
      st = |n[6:0];
      r = {1'b0, n[31:8]} + 25'(g & (st | n[8]));
      ex = 8'd158 - 8'(lz);
      if (r[24]) ex = ex + 8'd1;
      if (m == '0) i2f = '0;
      else i2f = {s, ex, r[24] ? r[23:1] : r[22:0]};
    end
  endfunction

endpackage

// File: design/typed_value_stack.sv
// Channel  Ports                       Transfer
// input    start, busy, in_item        start && !busy
// result   out_valid, out_item         out_valid, one cycle, no stall
// busy stays high after an accepted transaction through EXEC, TOP and CONV: stack
// update and write, top reread, then a registered conversion.
// The result is on the ports in the next cycle, when a new transaction can
// already be accepted; no new transaction is accepted while one is in progress.
// The registered memory read and the top reread set the rate.
// rst_n is synchronous and active low and empties the stack; results are never held.
module typed_value_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tvs_pkg::in_item_t   in_item,
  output logic                out_valid,
  output tvs_pkg::out_item_t  out_item
);
  import tvs_pkg::*;

  logic [32:0] mem [StackDepth];
  logic [32:0] rd_r;
  logic [AddrW-1:0] raddr;

  state_t state_r, state_nxt;
  in_item_t item_r;
  logic [CountW-1:0] count_r, count_nxt;
  logic [32:0] pop_r;
  logic unf_r, unf_nxt, ovf_r, ovf_nxt, popped_r, popped_nxt;
  logic we;
  logic [AddrW-1:0] waddr;
  logic [32:0] wdata;
  logic [31:0] value_r, value_nxt;
  logic [1:0] kind_r;
  logic outv_r;

  always_comb begin
    raddr = AddrW'(count_r - CountW'(1));
    if (state_r == ST_EXEC) raddr = AddrW'(count_r - CountW'(1));
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_TOP;
      ST_TOP:  state_nxt = ST_CONV;
      ST_CONV: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    unf_nxt = 1'b0;
    ovf_nxt = 1'b0;
    popped_nxt = 1'b0;
    we = 1'b0;
    waddr = AddrW'(count_r);
    wdata = {1'b1, item_r.payload};
    if (state_r == ST_EXEC) begin
      case (item_r.operation)
        OP_PUSH_INT, OP_PUSH_FLOAT, OP_DUP: begin
          if (item_r.operation == OP_DUP) wdata = rd_r;
          else wdata = {item_r.operation == OP_PUSH_INT, item_r.payload};
          if (item_r.operation == OP_DUP && count_r == '0) begin
            unf_nxt = 1'b1;
          end else if (count_r == CountW'(StackDepth)) begin
            ovf_nxt = 1'b1;
            we = 1'b1;
            waddr = AddrW'(StackDepth - 1);
          end else begin
            we = 1'b1;
            count_nxt = count_r + CountW'(1);
          end
        end
        OP_POP_INT, OP_POP_FLOAT: begin
          if (count_r == '0) unf_nxt = 1'b1;
          else begin
            popped_nxt = 1'b1;
            count_nxt = count_r - CountW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    value_nxt = '0;
    if (popped_r) begin
      if (item_r.operation == OP_POP_INT)
        value_nxt = pop_r[32] ? pop_r[31:0] : f2i(pop_r[31:0]);
      else
        value_nxt = pop_r[32] ? i2f(pop_r[31:0]) : pop_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      outv_r <= 1'b0;
      popped_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r <= (state_r == ST_CONV);
      if (state_r == ST_EXEC) begin
        count_r <= count_nxt;
        popped_r <= popped_nxt;
        unf_r <= unf_nxt;
        ovf_r <= ovf_nxt;
        pop_r <= rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) item_r <= in_item;
    if (state_r == ST_CONV) begin
      value_r <= value_nxt;
      if (count_r == '0) kind_r <= KIND_EMPTY;
      else kind_r <= rd_r[32] ? KIND_INT : KIND_FLOAT;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = outv_r;
  assign out_item = '{value: value_r, top_kind: kind_r, count: 9'(count_r),
                      underflow: unf_r, overflow: ovf_r};

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(StackDepth)) else $error("count above depth");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.underflow && out_item.overflow))
    else $error("both flags set");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |=> out_valid) else $error("missing result");
`endif

endmodule
